@@ sv/mtg_pkg.sv @@
// Shared constants, types and the tempering function of the Mersenne twister word generator.
package mtg_pkg;

  localparam int unsigned TBL_N = 624;
  localparam int unsigned TBL_M = 397;
  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] TBL_LAST     = IDX_W'(TBL_N - 1);
  localparam logic [IDX_W-1:0] IDX_ZERO     = '0;
  localparam logic [IDX_W-1:0] IDX_RESEED   = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_M        = IDX_W'(TBL_M);

  localparam logic [31:0] SEED_MUL     = 32'd69069;
  localparam logic [31:0] TWIST_XOR    = 32'd2567483615;
  localparam logic [31:0] TEMPER_B     = 32'd2636928640;
  localparam logic [31:0] TEMPER_C     = 32'd4022730752;
  localparam logic [31:0] DEFAULT_SEED = 32'h8f8f8f8f;

  localparam logic [2:0] ADDR_DEFAULT_SEED = 3'd0;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_SEED,
    DP_FILL,
    DP_PRIME,
    DP_LOAD,
    DP_TWIST,
    DP_READ,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      seed;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  function automatic logic [31:0] temper(input logic [31:0] w_in);
    logic [31:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

endpackage

@@ sv/mersenne_twister_generator.sv @@
// Top level of the Mersenne twister word generator with its configuration register.
// A next request with a nonzero index reads its word in ST_READ (one memory read per
// word); ST_DATA loads it tempered once the output is free; new requests wait for this.
// A next request at index 0 twists the table first (prime, load, twist sweep), after
// the fill from default_seed if no seed was ever used. A reseed also fills and twists.
// Reset clears the index, the seeded flag and the output valid; the table is not cleared.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // seed_value
  input  logic        in_tuser,     // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // random_word
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0]          default_seed_r;
  logic                 cfg_wr;
  mtg_pkg::dp_cmd_t     cmd;
  mtg_pkg::dp_status_t  status;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == mtg_pkg::ADDR_DEFAULT_SEED[2]);
  assign cfg_prdata = (cfg_paddr[2] == mtg_pkg::ADDR_DEFAULT_SEED[2]) ? default_seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_seed_r <= mtg_pkg::DEFAULT_SEED;
    end else if (cfg_wr) begin
      default_seed_r <= cfg_pwdata;
    end
  end

  mtg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .default_seed (default_seed_r),
    .status       (status),
    .cmd          (cmd)
  );

  mtg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/mtg_datapath.sv @@
// Datapath of the generator: table memory, seeding recurrence, twist step and tempered output.
module mtg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtg_pkg::dp_cmd_t     cmd,
  output mtg_pkg::dp_status_t  status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata   // random_word
);

  logic [31:0] mem [mtg_pkg::TBL_N];

  logic [31:0] x_r, x_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [31:0] rda_r, rdb_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic                       we;
  logic [mtg_pkg::IDX_W-1:0]  waddr;
  logic [31:0]                wdata;
  logic                       rda_en, rdb_en;
  logic [mtg_pkg::IDX_W-1:0]  rda_addr, rdb_addr;

  logic [mtg_pkg::IDX_W:0]    a_sum, b_sum;
  logic [mtg_pkg::IDX_W-1:0]  a_next, b_next;
  logic [31:0]                y;
  logic [31:0]                twisted;

  assign status.slot_free = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Addresses of the successor and the far tap for the step after this one, and this step's twisted word.
  always_comb begin
    a_sum  = {1'b0, cmd.idx} + (mtg_pkg::IDX_W+1)'(2);
    b_sum  = {1'b0, cmd.idx} + {1'b0, mtg_pkg::IDX_M} + (mtg_pkg::IDX_W+1)'(1);
    a_next = (a_sum >= (mtg_pkg::IDX_W+1)'(mtg_pkg::TBL_N))
           ? mtg_pkg::IDX_W'(a_sum - (mtg_pkg::IDX_W+1)'(mtg_pkg::TBL_N))
           : a_sum[mtg_pkg::IDX_W-1:0];
    b_next = (b_sum >= (mtg_pkg::IDX_W+1)'(mtg_pkg::TBL_N))
           ? mtg_pkg::IDX_W'(b_sum - (mtg_pkg::IDX_W+1)'(mtg_pkg::TBL_N))
           : b_sum[mtg_pkg::IDX_W-1:0];
    y       = {cur_r[31], rda_r[30:0]};
    twisted = rdb_r ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'd0);
  end

  always_comb begin
    x_nxt         = x_r;
    cur_nxt       = cur_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we            = 1'b0;
    waddr         = cmd.idx;
    wdata         = x_r;
    rda_en        = 1'b0;
    rdb_en        = 1'b0;
    rda_addr      = cmd.idx;
    rdb_addr      = b_next;
    case (cmd.op)
      mtg_pkg::DP_SEED: begin
        x_nxt = cmd.seed;
      end
      mtg_pkg::DP_FILL: begin
        we    = 1'b1;
        wdata = x_r;
        x_nxt = x_r * mtg_pkg::SEED_MUL + 32'd1;
      end
      mtg_pkg::DP_PRIME: begin
        rda_en   = 1'b1;
        rda_addr = mtg_pkg::IDX_ZERO;
      end
      mtg_pkg::DP_LOAD: begin
        cur_nxt  = rda_r;
        rda_en   = 1'b1;
        rdb_en   = 1'b1;
        rda_addr = mtg_pkg::IDX_RESEED;
        rdb_addr = mtg_pkg::IDX_M;
      end
      mtg_pkg::DP_TWIST: begin
        we       = 1'b1;
        wdata    = twisted;
        cur_nxt  = rda_r;
        rda_en   = 1'b1;
        rdb_en   = 1'b1;
        rda_addr = a_next;
        rdb_addr = b_next;
      end
      mtg_pkg::DP_READ: begin
        rda_en = 1'b1;
      end
      mtg_pkg::DP_OUT: begin
        out_data_nxt  = mtg_pkg::temper(rda_r);
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rda_en) begin
      rda_r <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_r <= mem[rdb_addr];
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mtg_pkg::DP_OUT) |-> status.slot_free)
    else $error("result loaded while the output word is still held");

  a_twist_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mtg_pkg::DP_TWIST) |-> (rda_addr != waddr) && (rdb_addr != waddr))
    else $error("twist step reads the entry it writes");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("output word changed before it was taken");

endmodule

@@ sv/mtg_ctrl.sv @@
// Controller of the generator: request decode, fill and twist sequencing, read index.
module mtg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [31:0]          in_tdata,
  input  logic [31:0]          default_seed,
  input  mtg_pkg::dp_status_t  status,
  output mtg_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PRIME,
    ST_LOAD,
    ST_TWIST,
    ST_READ,
    ST_DATA
  } state_t;

  state_t                    state_r, state_nxt;
  logic [mtg_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [mtg_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      seeded_r, seeded_nxt;
  logic                      reseed_r, reseed_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    seeded_nxt = seeded_r;
    reseed_nxt = reseed_r;
    cmd.op     = mtg_pkg::DP_NOP;
    cmd.idx    = cnt_r;
    cmd.seed   = in_tdata;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.op     = mtg_pkg::DP_SEED;
            seeded_nxt = 1'b1;
            reseed_nxt = 1'b1;
            cnt_nxt    = mtg_pkg::IDX_ZERO;
            state_nxt  = ST_FILL;
          end else if (idx_r == mtg_pkg::IDX_ZERO) begin
            reseed_nxt = 1'b0;
            if (!seeded_r) begin
              cmd.op     = mtg_pkg::DP_SEED;
              cmd.seed   = default_seed;
              seeded_nxt = 1'b1;
              cnt_nxt    = mtg_pkg::IDX_ZERO;
              state_nxt  = ST_FILL;
            end else begin
              state_nxt = ST_PRIME;
            end
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_FILL: begin
        cmd.op = mtg_pkg::DP_FILL;
        if (cnt_r == mtg_pkg::TBL_LAST) begin
          cnt_nxt   = mtg_pkg::IDX_ZERO;
          state_nxt = ST_PRIME;
        end else begin
          cnt_nxt = cnt_r + mtg_pkg::IDX_W'(1);
        end
      end
      ST_PRIME: begin
        cmd.op    = mtg_pkg::DP_PRIME;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.op    = mtg_pkg::DP_LOAD;
        cnt_nxt   = mtg_pkg::IDX_ZERO;
        state_nxt = ST_TWIST;
      end
      ST_TWIST: begin
        cmd.op = mtg_pkg::DP_TWIST;
        if (cnt_r == mtg_pkg::TBL_LAST) begin
          idx_nxt   = reseed_r ? mtg_pkg::IDX_RESEED : mtg_pkg::IDX_ZERO;
          state_nxt = ST_READ;
        end else begin
          cnt_nxt = cnt_r + mtg_pkg::IDX_W'(1);
        end
      end
      ST_READ: begin
        cmd.op    = mtg_pkg::DP_READ;
        cmd.idx   = idx_r;
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        cmd.idx = idx_r;
        if (status.slot_free) begin
          cmd.op    = mtg_pkg::DP_OUT;
          idx_nxt   = (idx_r == mtg_pkg::TBL_LAST) ? mtg_pkg::IDX_ZERO
                                                   : idx_r + mtg_pkg::IDX_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      seeded_r <= 1'b0;
      reseed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      seeded_r <= seeded_nxt;
      reseed_r <= reseed_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mtg_pkg::TBL_LAST)
    else $error("read index left the table");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mtg_pkg::TBL_LAST)
    else $error("sweep counter left the table");

  a_twist_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRIME) |-> seeded_r)
    else $error("twist started on an unseeded table");

  a_reseed_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TWIST && cnt_r == mtg_pkg::TBL_LAST && reseed_r) |=>
    (idx_r == mtg_pkg::IDX_RESEED))
    else $error("reseed did not move the read index to entry one");

endmodule
